### hw/rtl/ccmc_pkg.sv
// shared types and codes for the contactor sequencer with mirror check
`default_nettype none

package ccmc_pkg;

    // event codes carried in the command field
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_OPEN  = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;
    localparam logic [2:0] CMD_TICK  = 3'd5;
    localparam logic [2:0] CMD_BTICK = 3'd6;

    // sequencer modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_OPEN      = 3'd1;
    localparam logic [2:0] MODE_DRV_CLOSE = 3'd2;
    localparam logic [2:0] MODE_CLOSED    = 3'd3;
    localparam logic [2:0] MODE_DRV_OPEN  = 3'd4;

    // saved / re-queued request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_OPEN  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    // outlet report codes
    localparam logic [1:0] RPT_NONE      = 2'd0;
    localparam logic [1:0] RPT_UNPOWERED = 2'd1;
    localparam logic [1:0] RPT_POWERED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CONTACTOR_FITTED = 2'd0;
    localparam logic [1:0] CFG_BREAKER_FITTED   = 2'd1;
    localparam logic [1:0] CFG_MIRROR_CHECK_ON  = 2'd2;

    // probe ticks before the mirror sample
    localparam logic [1:0] PROBE_TICKS = 2'd2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic contactor_fitted;
        logic breaker_fitted;
        logic mirror_check_on;
    } cfg_t;

    typedef struct packed {
        logic [2:0] command;
        logic       mirror_raw_closed;
        logic       mirror_filtered_set;
        logic       evse_suspend_or_later;
        logic       evse_at_suspend;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       check_enabled;
        logic       fault_flag;
        logic [1:0] probe_count;
        logic [1:0] saved_request;
        logic       coil_level;
        logic       trip_level;
        logic       probe_level;
    } seq_state_t;

    typedef struct packed {
        logic [2:0] state_code;
        logic       contactor_coil;
        logic       breaker_coil;
        logic       probe_power;
        logic [1:0] outlet_report;
        logic       restart_state_timer;
        logic       start_breaker_timer;
        logic       fault_event;
        logic       rearm_off_event;
        logic [1:0] self_request;
        logic       mirror_fault;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/contactor_control_with_mirror_check.sv
// top level: contactor sequencer with mirror-contact supervision
// a request is held in the input register, then its result is registered in the result register
// throughput: one request per cycle unless m_tready stalls the result register; the core state update is combinational
// the input register is freed as soon as the result register can take its result
// reset (rst_n low, asynchronous): sequencer idle, all levels low, register defaults
// contactor_fitted=1, breaker_fitted=0, mirror_check_on=0, both stages empty
`default_nettype none

module contactor_control_with_mirror_check
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [0:0] cfg_data,

    // requests in
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // lowest bit up: command[2:0], mirror_raw_closed, mirror_filtered_set,
    // evse_suspend_or_later, evse_at_suspend, zero pad
    input  wire logic [7:0] s_tdata,

    // results out
    output logic            m_tvalid,
    input  wire logic       m_tready,
    // lowest bit up: state_code[2:0], contactor_coil, breaker_coil, probe_power,
    // outlet_report[1:0], restart_state_timer, start_breaker_timer, fault_event,
    // rearm_off_event, self_request[1:0], mirror_fault, zero pad
    output logic [15:0]     m_tdata
);
    import ccmc_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;

    // input stage
    logic       in_valid_reg;
    item_t      in_item_reg;

    // sequencer state
    seq_state_t state_reg;
    seq_state_t state_next;

    // result stage
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;

    logic       in_fire;
    logic       advance;
    logic       step;

    // result register can take a new result when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    // the input stage steps the sequencer when it holds a request and can move on
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contactor_fitted <= 1'b1;
            cfg_reg.breaker_fitted   <= 1'b0;
            cfg_reg.mirror_check_on  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTACTOR_FITTED: cfg_reg.contactor_fitted <= cfg_data[0];
                CFG_BREAKER_FITTED:   cfg_reg.breaker_fitted   <= cfg_data[0];
                CFG_MIRROR_CHECK_ON:  cfg_reg.mirror_check_on  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.command               <= s_tdata[2:0];
            in_item_reg.mirror_raw_closed     <= s_tdata[3];
            in_item_reg.mirror_filtered_set   <= s_tdata[4];
            in_item_reg.evse_suspend_or_later <= s_tdata[5];
            in_item_reg.evse_at_suspend       <= s_tdata[6];
        end
    end

    ccmc_core u_core
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // sequencer state only moves when a request is stepped through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.check_enabled <= 1'b0;
            state_reg.fault_flag    <= 1'b0;
            state_reg.probe_count   <= 2'd0;
            state_reg.saved_request <= REQ_NONE;
            state_reg.coil_level    <= 1'b0;
            state_reg.trip_level    <= 1'b0;
            state_reg.probe_level   <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.mirror_fault,
                       out_result_reg.self_request,
                       out_result_reg.rearm_off_event,
                       out_result_reg.fault_event,
                       out_result_reg.start_breaker_timer,
                       out_result_reg.restart_state_timer,
                       out_result_reg.outlet_report,
                       out_result_reg.probe_power,
                       out_result_reg.breaker_coil,
                       out_result_reg.contactor_coil,
                       out_result_reg.state_code};

`ifndef SYNTHESIS
    // sequencer state never moves without a request being stepped
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg))
        else $error("sequencer state changed without a request");

    // the probe counter stops at the sampling tick
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.probe_count != 2'd3)
        else $error("probe counter ran past the sampling tick");

    // a fault event always reports the fault flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.fault_event) |-> result.mirror_fault)
        else $error("fault event without fault flag");

    // rearm off only goes with a breaker trip on the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.rearm_off_event) |-> (result.breaker_coil
            && result.start_breaker_timer && cfg_reg.breaker_fitted))
        else $error("rearm off without breaker trip");
`endif

endmodule

`default_nettype wire

### hw/rtl/ccmc_core.sv
// next-state and result logic of the contactor sequencer for one event
`default_nettype none

module ccmc_core
(
    input  ccmc_pkg::cfg_t       cfg,
    input  ccmc_pkg::seq_state_t state,
    input  ccmc_pkg::item_t      item,
    output ccmc_pkg::seq_state_t state_next,
    output ccmc_pkg::result_t    result
);
    import ccmc_pkg::*;

    seq_state_t s;
    logic [1:0] report;
    logic       restart;
    logic       btimer;
    logic       fault_ev;
    logic       rearm;
    logic [1:0] self_req;
    logic       do_tick;
    logic       bad;

    always_comb
    begin
        s        = state;
        report   = RPT_NONE;
        restart  = 1'b0;
        btimer   = 1'b0;
        fault_ev = 1'b0;
        rearm    = 1'b0;
        self_req = REQ_NONE;
        do_tick  = 1'b0;
        bad      = 1'b0;

        if (item.command == CMD_BTICK)
        begin
            s.trip_level = 1'b0;
        end
        if (item.command == CMD_STOP)
        begin
            s.mode = MODE_IDLE;
        end

        case (s.mode)
            MODE_IDLE:
            begin
                if (item.command == CMD_START)
                begin
                    if (!cfg.contactor_fitted || !item.mirror_raw_closed)
                    begin
                        s.check_enabled = 1'b1;
                        s.mode          = MODE_OPEN;
                        report          = RPT_UNPOWERED;
                    end
                    else
                    begin
                        s.mode   = MODE_CLOSED;
                        report   = RPT_POWERED;
                        self_req = REQ_OPEN;
                    end
                    restart = 1'b1;
                end
            end
            MODE_OPEN:
            begin
                if (item.command == CMD_OPEN && item.evse_suspend_or_later)
                begin
                    // soft reinit
                    s.fault_flag    = 1'b0;
                    s.probe_count   = 2'd0;
                    s.check_enabled = 1'b0;
                    s.saved_request = REQ_NONE;
                    s.mode          = MODE_IDLE;
                end
                else if (item.command == CMD_CLOSE)
                begin
                    report = RPT_POWERED;
                    if (!cfg.contactor_fitted)
                    begin
                        s.mode = MODE_CLOSED;
                    end
                    else
                    begin
                        s.coil_level = 1'b1;
                        s.mode       = MODE_DRV_CLOSE;
                    end
                end
                else if (s.check_enabled && item.command == CMD_TICK)
                begin
                    do_tick = 1'b1;
                    bad     = cfg.mirror_check_on && !item.mirror_filtered_set
                              && !item.evse_at_suspend;
                end
                restart = 1'b1;
            end
            MODE_DRV_CLOSE:
            begin
                if (item.command == CMD_OPEN)
                begin
                    s.saved_request = REQ_OPEN;
                end
                else if (item.command == CMD_TICK)
                begin
                    s.mode = MODE_CLOSED;
                    if (s.saved_request == REQ_OPEN)
                    begin
                        self_req = REQ_OPEN;
                    end
                    s.probe_count = 2'd0;
                    restart       = 1'b1;
                end
            end
            MODE_CLOSED:
            begin
                if (item.command == CMD_OPEN || s.saved_request == REQ_OPEN)
                begin
                    report          = RPT_UNPOWERED;
                    s.saved_request = REQ_NONE;
                    if (!cfg.contactor_fitted)
                    begin
                        s.check_enabled = 1'b1;
                        s.mode          = MODE_OPEN;
                    end
                    else
                    begin
                        s.coil_level = 1'b0;
                        s.mode       = MODE_DRV_OPEN;
                        if (item.command == CMD_OPEN && item.evse_suspend_or_later)
                        begin
                            s.fault_flag    = 1'b0;
                            s.probe_count   = 2'd0;
                            s.check_enabled = 1'b0;
                            s.saved_request = REQ_NONE;
                            s.mode          = MODE_IDLE;
                        end
                    end
                end
                else if (s.check_enabled && item.command == CMD_TICK)
                begin
                    do_tick = 1'b1;
                    bad     = cfg.mirror_check_on && item.mirror_filtered_set;
                end
                restart = 1'b1;
            end
            MODE_DRV_OPEN:
            begin
                if (item.command == CMD_CLOSE)
                begin
                    s.saved_request = REQ_CLOSE;
                end
                else if (item.command == CMD_TICK)
                begin
                    s.check_enabled = 1'b1;
                    s.mode          = MODE_OPEN;
                    if (s.saved_request == REQ_CLOSE)
                    begin
                        self_req = REQ_CLOSE;
                    end
                    s.probe_count   = 2'd0;
                    s.saved_request = REQ_NONE;
                    restart         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // mirror check tick: probe first, then sample
        if (do_tick)
        begin
            if (s.probe_count < PROBE_TICKS)
            begin
                s.probe_level = 1'b1;
                s.probe_count = s.probe_count + 2'd1;
            end
            else
            begin
                if (bad)
                begin
                    if (!s.fault_flag)
                    begin
                        if (cfg.breaker_fitted)
                        begin
                            s.trip_level = 1'b1;
                            rearm        = 1'b1;
                        end
                        btimer   = 1'b1;
                        fault_ev = 1'b1;
                    end
                    s.fault_flag = 1'b1;
                end
                else
                begin
                    s.fault_flag = 1'b0;
                end
                s.probe_level = 1'b0;
                s.probe_count = 2'd0;
            end
        end
    end

    assign state_next = s;

    assign result.state_code          = s.mode;
    assign result.contactor_coil      = s.coil_level;
    assign result.breaker_coil        = s.trip_level;
    assign result.probe_power         = s.probe_level;
    assign result.outlet_report       = report;
    assign result.restart_state_timer = restart;
    assign result.start_breaker_timer = btimer;
    assign result.fault_event         = fault_ev;
    assign result.rearm_off_event     = rearm;
    assign result.self_request        = self_req;
    assign result.mirror_fault        = s.fault_flag;

endmodule

`default_nettype wire

### verif/contactor_control_with_mirror_check_tb.sv
// self-checking testbench for the contactor sequencer with mirror-contact check
`timescale 1ns / 1ps

module contactor_control_with_mirror_check_tb;

    import ccmc_pkg::*;

    // command code with no meaning, must behave like none
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // every setting of contactor_fitted, breaker_fitted, mirror_check_on
    localparam int N_PLANS = 8;
    localparam int EVENTS_PER_PLAN = 55;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_CONTACTOR_FITTED;
    logic [0:0] cfg_data = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // lowest bit up: command[2:0], mirror_raw_closed, mirror_filtered_set,
    // evse_suspend_or_later, evse_at_suspend, zero pad
    logic [7:0]  s_tdata = 8'h00;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // lowest bit up: state_code[2:0], contactor_coil, breaker_coil, probe_power,
    // outlet_report[1:0], restart_state_timer, start_breaker_timer, fault_event,
    // rearm_off_event, self_request[1:0], mirror_fault, zero pad
    logic [15:0] m_tdata;

    contactor_control_with_mirror_check i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow of the sequencer: register copies and state after reset
    // ------------------------------------------------------------------
    logic       fit_contactor = 1'b1;
    logic       fit_breaker = 1'b0;
    logic       mirror_sup_on = 1'b0;

    logic [2:0] seq_mode = MODE_IDLE;
    logic       seq_check_on = 1'b0;
    logic       seq_fault = 1'b0;
    logic [1:0] seq_probe_cnt = 2'd0;
    logic [1:0] seq_saved = REQ_NONE;
    logic       seq_coil = 1'b0;
    logic       seq_trip = 1'b0;
    logic       seq_probe = 1'b0;

    item_t   events_to_send[$];
    result_t results_due[$];

    int failures = 0;
    int events_sent = 0;
    int results_checked = 0;
    int faults_seen = 0;
    int self_requests_seen = 0;

    // one state-timer tick of the mirror check: two probe ticks, then a sample
    function automatic void probe_mirror(input logic bad, inout result_t r);
        if (seq_probe_cnt < PROBE_TICKS)
        begin
            seq_probe = 1'b1;
            seq_probe_cnt = seq_probe_cnt + 2'd1;
            return;
        end
        if (bad)
        begin
            // only a fresh fault trips the breaker and raises the event
            if (!seq_fault)
            begin
                if (fit_breaker)
                begin
                    seq_trip = 1'b1;
                    r.rearm_off_event = 1'b1;
                end
                r.start_breaker_timer = 1'b1;
                r.fault_event = 1'b1;
            end
            seq_fault = 1'b1;
        end
        else
        begin
            seq_fault = 1'b0;
        end
        seq_probe = 1'b0;
        seq_probe_cnt = 2'd0;
    endfunction

    // soft reinit back to idle, coil and probe levels untouched
    function automatic void back_to_idle();
        seq_fault = 1'b0;
        seq_probe_cnt = 2'd0;
        seq_check_on = 1'b0;
        seq_saved = REQ_NONE;
        seq_mode = MODE_IDLE;
    endfunction

    // advance the shadow sequencer by one request and give the result it causes
    function automatic result_t step_sequencer(input item_t ev);
        result_t r;
        r = '0;
        r.outlet_report = RPT_NONE;
        r.self_request = REQ_NONE;

        // breaker tick releases the trip coil before anything else
        if (ev.command == CMD_BTICK)
            seq_trip = 1'b0;
        // stop forces idle, levels stay as they are
        if (ev.command == CMD_STOP)
            seq_mode = MODE_IDLE;

        case (seq_mode)
            MODE_IDLE:
            begin
                if (ev.command == CMD_START)
                begin
                    if (!fit_contactor || !ev.mirror_raw_closed)
                    begin
                        seq_check_on = 1'b1;
                        seq_mode = MODE_OPEN;
                        r.outlet_report = RPT_UNPOWERED;
                    end
                    else
                    begin
                        // contact already reads closed: go closed, then ask to open
                        seq_mode = MODE_CLOSED;
                        r.outlet_report = RPT_POWERED;
                        r.self_request = REQ_OPEN;
                    end
                    r.restart_state_timer = 1'b1;
                end
            end
            MODE_OPEN:
            begin
                if (ev.command == CMD_OPEN && ev.evse_suspend_or_later)
                begin
                    back_to_idle();
                end
                else if (ev.command == CMD_CLOSE)
                begin
                    r.outlet_report = RPT_POWERED;
                    if (!fit_contactor)
                    begin
                        seq_mode = MODE_CLOSED;
                    end
                    else
                    begin
                        seq_coil = 1'b1;
                        seq_mode = MODE_DRV_CLOSE;
                    end
                end
                else if (seq_check_on && ev.command == CMD_TICK)
                begin
                    // open contactor: mirror must read set unless at suspend
                    probe_mirror(mirror_sup_on && !ev.mirror_filtered_set &&
                                 !ev.evse_at_suspend, r);
                end
                r.restart_state_timer = 1'b1;
            end
            MODE_DRV_CLOSE:
            begin
                if (ev.command == CMD_OPEN)
                begin
                    seq_saved = REQ_OPEN;
                end
                else if (ev.command == CMD_TICK)
                begin
                    // saved open is not cleared here, the closed state acts on it
                    seq_mode = MODE_CLOSED;
                    if (seq_saved == REQ_OPEN)
                        r.self_request = REQ_OPEN;
                    seq_probe_cnt = 2'd0;
                    r.restart_state_timer = 1'b1;
                end
            end
            MODE_CLOSED:
            begin
                if (ev.command == CMD_OPEN || seq_saved == REQ_OPEN)
                begin
                    r.outlet_report = RPT_UNPOWERED;
                    seq_saved = REQ_NONE;
                    if (!fit_contactor)
                    begin
                        seq_check_on = 1'b1;
                        seq_mode = MODE_OPEN;
                    end
                    else
                    begin
                        seq_coil = 1'b0;
                        seq_mode = MODE_DRV_OPEN;
                        if (ev.command == CMD_OPEN && ev.evse_suspend_or_later)
                            back_to_idle();
                    end
                end
                else if (seq_check_on && ev.command == CMD_TICK)
                begin
                    // closed contactor: a set mirror means a welded or stuck reading
                    probe_mirror(mirror_sup_on && ev.mirror_filtered_set, r);
                end
                r.restart_state_timer = 1'b1;
            end
            MODE_DRV_OPEN:
            begin
                if (ev.command == CMD_CLOSE)
                begin
                    seq_saved = REQ_CLOSE;
                end
                else if (ev.command == CMD_TICK)
                begin
                    seq_check_on = 1'b1;
                    seq_mode = MODE_OPEN;
                    if (seq_saved == REQ_CLOSE)
                        r.self_request = REQ_CLOSE;
                    seq_probe_cnt = 2'd0;
                    seq_saved = REQ_NONE;
                    r.restart_state_timer = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        r.state_code = seq_mode;
        r.contactor_coil = seq_coil;
        r.breaker_coil = seq_trip;
        r.probe_power = seq_probe;
        r.mirror_fault = seq_fault;
        return r;
    endfunction

    function automatic logic [7:0] pack_event(input item_t ev);
        return {1'b0, ev.evse_at_suspend, ev.evse_suspend_or_later,
                ev.mirror_filtered_set, ev.mirror_raw_closed, ev.command};
    endfunction

    function automatic result_t unpack_result(input logic [15:0] d);
        result_t r;
        r.state_code = d[2:0];
        r.contactor_coil = d[3];
        r.breaker_coil = d[4];
        r.probe_power = d[5];
        r.outlet_report = d[7:6];
        r.restart_state_timer = d[8];
        r.start_breaker_timer = d[9];
        r.fault_event = d[10];
        r.rearm_off_event = d[11];
        r.self_request = d[13:12];
        r.mirror_fault = d[14];
        return r;
    endfunction

    function automatic item_t make_event(input logic [2:0] cmd, input logic raw,
                                         input logic filt, input logic later,
                                         input logic at_susp);
        item_t ev;
        ev.command = cmd;
        ev.mirror_raw_closed = raw;
        ev.mirror_filtered_set = filt;
        ev.evse_suspend_or_later = later;
        ev.evse_at_suspend = at_susp;
        return ev;
    endfunction

    // weighted so the sequencer keeps cycling through all five states,
    // with stop and junk commands as noise
    function automatic item_t random_event();
        int unsigned pick;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            cmd = CMD_START;
        else if (pick < 14)
            cmd = CMD_STOP;
        else if (pick < 32)
            cmd = CMD_OPEN;
        else if (pick < 50)
            cmd = CMD_CLOSE;
        else if (pick < 85)
            cmd = CMD_TICK;
        else if (pick < 92)
            cmd = CMD_BTICK;
        else if (pick < 97)
            cmd = CMD_NONE;
        else
            cmd = CMD_UNUSED;
        // suspend flags kept rare so soft reinit does not dominate
        return make_event(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    endfunction

    task automatic check_field(input string field_name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", field_name, want_v, got_v);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    item_t      in_flight;
    logic       next_valid;
    logic [7:0] next_data;
    int         burst_left = 0;
    int         gap_left = 0;

    always @(posedge clk)
    begin
        next_valid = s_tvalid;
        next_data = s_tdata;
        if (s_tvalid && s_tready)
        begin
            results_due.push_back(step_sequencer(in_flight));
            events_sent++;
            next_valid = 1'b0;
        end
        if (rst_n && !next_valid && events_to_send.size() != 0)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else
            begin
                in_flight = events_to_send.pop_front();
                next_valid = 1'b1;
                next_data = pack_event(in_flight);
                if (burst_left <= 1)
                begin
                    // end of burst: pick the next one, sometimes with no gap at all
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
        // a valid that stays high is assigned once, never dropped and raised
        s_tvalid <= next_valid;
        s_tdata <= next_data;
    end

    // ------------------------------------------------------------------
    // result side: ready follows a stall style that is picked anew at random when its run ends
    // ------------------------------------------------------------------
    int unsigned stall_style = 0;
    int unsigned stall_run = 0;

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_run <= $urandom_range(16, 80);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_run[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result checker: each accepted result against the oldest expectation
    result_t want;
    result_t got;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", m_tdata);
                failures++;
            end
            else
            begin
                want = results_due.pop_front();
                got = unpack_result(m_tdata);
                check_field("state_code", want.state_code, got.state_code);
                check_field("contactor_coil", want.contactor_coil, got.contactor_coil);
                check_field("breaker_coil", want.breaker_coil, got.breaker_coil);
                check_field("probe_power", want.probe_power, got.probe_power);
                check_field("outlet_report", want.outlet_report, got.outlet_report);
                check_field("restart_state_timer", want.restart_state_timer,
                            got.restart_state_timer);
                check_field("start_breaker_timer", want.start_breaker_timer,
                            got.start_breaker_timer);
                check_field("fault_event", want.fault_event, got.fault_event);
                check_field("rearm_off_event", want.rearm_off_event, got.rearm_off_event);
                check_field("self_request", want.self_request, got.self_request);
                check_field("mirror_fault", want.mirror_fault, got.mirror_fault);
                check_field("pad", 0, m_tdata[15]);
                results_checked++;
                if (want.fault_event)
                    faults_seen++;
                if (want.self_request != REQ_NONE)
                    self_requests_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencing of the run
    // ------------------------------------------------------------------

    // writes all three registers, one per edge, while the block is idle
    task automatic apply_settings(input logic [2:0] plan);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CONTACTOR_FITTED;
        cfg_data <= plan[2];
        fit_contactor = plan[2];
        @(posedge clk);
        cfg_index <= CFG_BREAKER_FITTED;
        cfg_data <= plan[1];
        fit_breaker = plan[1];
        @(posedge clk);
        cfg_index <= CFG_MIRROR_CHECK_ON;
        cfg_data <= plan[0];
        mirror_sup_on = plan[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every request sent and every result back, then let the pipe empty
    // (checked away from the rising edge so the driver's updates have settled)
    task automatic drain();
        while (events_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    logic [2:0] settings_plan [N_PLANS] = '{3'b111, 3'b000, 3'b101, 3'b011,
                                           3'b110, 3'b001, 3'b100, 3'b010};

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed walk with everything fitted and supervision on
        apply_settings(3'b111);
        // none and the unused code with every flag high, in idle
        events_to_send.push_back(make_event(CMD_NONE, 1, 1, 1, 1));
        events_to_send.push_back(make_event(CMD_UNUSED, 1, 1, 1, 1));
        // start with contact open, then a full mirror check ending in a fault
        events_to_send.push_back(make_event(CMD_START, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 0, 0, 0));
        // breaker tick releases the trip coil
        events_to_send.push_back(make_event(CMD_BTICK, 0, 1, 0, 0));
        // close, open saved while driving, re-sent open when closing ends
        events_to_send.push_back(make_event(CMD_CLOSE, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_OPEN, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        // saved open acts on any event in closed
        events_to_send.push_back(make_event(CMD_NONE, 0, 1, 0, 0));
        // close saved while driving open, re-sent on the tick
        events_to_send.push_back(make_event(CMD_CLOSE, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        // open at or past suspend from open: soft reinit
        events_to_send.push_back(make_event(CMD_OPEN, 0, 1, 1, 0));
        // start with contact closed goes straight to closed
        events_to_send.push_back(make_event(CMD_START, 1, 0, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 1, 0, 0, 0));
        events_to_send.push_back(make_event(CMD_OPEN, 0, 0, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 0, 0, 0));
        events_to_send.push_back(make_event(CMD_CLOSE, 0, 0, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 0, 0, 0));
        // mirror reads set while closed: fault on the sampling tick
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        events_to_send.push_back(make_event(CMD_TICK, 0, 1, 0, 0));
        // open at suspend from closed: coil released, then soft reinit
        events_to_send.push_back(make_event(CMD_OPEN, 0, 1, 1, 1));
        events_to_send.push_back(make_event(CMD_STOP, 1, 1, 1, 1));
        drain();

        // random phases, one per register setting
        for (int p = 0; p < N_PLANS; p++)
        begin
            apply_settings(settings_plan[p]);
            for (int k = 0; k < EVENTS_PER_PLAN; k++)
                events_to_send.push_back(random_event());
            drain();
        end

        $display("covered %0d requests over %0d register settings: %0d results checked,",
                 events_sent, N_PLANS + 1, results_checked);
        $display("  %0d new mirror faults and %0d re-sent requests seen",
                 faults_seen, self_requests_seen);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
